// ===== rtl/mhdg_pkg.sv =====
// ---------------------------------------------------------------------------
// mhdg_pkg: shared types and constants of the magnetometer heading block
// Register indexes, chip variant codes, datapath widths, the queued word and
// the arctangent table of the CORDIC.
// ---------------------------------------------------------------------------
package mhdg_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int TABLE_LEN        = 24;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_VARIANT = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_DECL    = 1'b1;

  localparam logic [1:0] VARIANT_NONE = 2'd0;
  localparam logic [1:0] VARIANT_LE   = 2'd1;
  localparam logic [1:0] VARIANT_BE   = 2'd2;

  localparam int AXIS_W = 16;
  localparam int XY_W   = 28;
  localparam int ANG_W  = 27;
  localparam int NUM_W  = 34;
  localparam int Q_W    = NUM_W - 16;
  localparam int HD_W   = 18;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  localparam logic signed [ANG_W-1:0] HALF_TURN_ANG = 27'sd11796480;
  localparam logic signed [Q_W-1:0]   HALF_TURN_Q   = 18'sd18000;
  localparam logic signed [AXIS_W-1:0] HALF_TURN_DECL = 16'sd18000;
  localparam logic signed [HD_W-1:0]  FULL_TURN_HD  = 18'sd36000;
  localparam logic signed [NUM_W-1:0] CD_PER_DEG    = 34'sd100;
  localparam logic signed [NUM_W-1:0] ROUND_HALF    = 34'sd32768;

  typedef struct packed {
    logic                     ok;
    logic                     zero;
    logic signed [AXIS_W-1:0] x;
    logic signed [AXIS_W-1:0] y;
    logic signed [AXIS_W-1:0] z;
  } item_t;

  function automatic logic signed [ANG_W-1:0] atan_entry(input int idx);
    logic signed [ANG_W-1:0] v;
    unique case (idx)
      0:  v = 27'sd2949120;
      1:  v = 27'sd1740967;
      2:  v = 27'sd919879;
      3:  v = 27'sd466945;
      4:  v = 27'sd234379;
      5:  v = 27'sd117304;
      6:  v = 27'sd58666;
      7:  v = 27'sd29335;
      8:  v = 27'sd14668;
      9:  v = 27'sd7334;
      10: v = 27'sd3667;
      11: v = 27'sd1833;
      12: v = 27'sd917;
      13: v = 27'sd458;
      14: v = 27'sd229;
      15: v = 27'sd115;
      16: v = 27'sd57;
      17: v = 27'sd29;
      18: v = 27'sd14;
      19: v = 27'sd7;
      20: v = 27'sd4;
      21: v = 27'sd2;
      22: v = 27'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/mhdg_front.sv =====
// ---------------------------------------------------------------------------
// mhdg_front: input stage
// Accepts a raw read, unpacks the three axes in the layout of the configured
// chip and marks whether the word is valid and whether X and Y are both zero.
// ---------------------------------------------------------------------------
module mhdg_front
  import mhdg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic [1:0]  variant,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,
  input  logic        s_axis_tuser,
  input  logic        q_full,
  output logic        q_push,
  output item_t       q_item
);

  logic  front_vld;
  item_t front_item;
  item_t item_next;
  logic  accept;

  always_comb begin
    item_next    = '0;
    item_next.ok = s_axis_tuser && (variant == VARIANT_LE || variant == VARIANT_BE);
    unique case (variant)
      VARIANT_LE: begin
        item_next.x = {s_axis_tdata[15:8], s_axis_tdata[7:0]};
        item_next.y = {s_axis_tdata[31:24], s_axis_tdata[23:16]};
        item_next.z = {s_axis_tdata[47:40], s_axis_tdata[39:32]};
      end
      VARIANT_BE: begin
        item_next.x = {s_axis_tdata[7:0], s_axis_tdata[15:8]};
        item_next.z = {s_axis_tdata[23:16], s_axis_tdata[31:24]};
        item_next.y = {s_axis_tdata[39:32], s_axis_tdata[47:40]};
      end
      default: begin
        item_next.x = '0;
        item_next.y = '0;
        item_next.z = '0;
      end
    endcase
    if (!item_next.ok) begin
      item_next.x = '0;
      item_next.y = '0;
      item_next.z = '0;
    end
    item_next.zero = (item_next.x == '0) && (item_next.y == '0);
  end

  assign q_push        = front_vld && !q_full;
  assign s_axis_tready = !front_vld || !q_full;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign q_item        = front_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      front_vld <= 1'b0;
    end else if (accept) begin
      front_vld <= 1'b1;
    end else if (q_push) begin
      front_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      front_item <= item_next;
    end
  end

endmodule

// ===== rtl/mhdg_queue.sv =====
// ---------------------------------------------------------------------------
// mhdg_queue: short queue between the input stage and the heading pipeline
// A four-entry first-in first-out buffer of unpacked words.
// ---------------------------------------------------------------------------
module mhdg_queue
  import mhdg_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output item_t pop_item,
  output logic  empty
);

  item_t             entries [0:QUEUE_DEPTH-1];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full     = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_item = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

// ===== rtl/mhdg_back.sv =====
// ---------------------------------------------------------------------------
// mhdg_back: heading pipeline
// Half-plane pre-rotation, one CORDIC vectoring step per stage, conversion
// to centidegrees, declination and wrap, and the output register.
// ---------------------------------------------------------------------------
module mhdg_back
  import mhdg_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic signed [AXIS_W-1:0] decl,
  input  logic                     q_empty,
  input  item_t                    q_item,
  output logic                     q_pop,
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [63:0]              m_axis_tdata,
  output logic                     m_axis_tuser
);

  logic                    advance;
  logic signed [XY_W-1:0]  cx  [0:CORDIC_STEPS];
  logic signed [XY_W-1:0]  cy  [0:CORDIC_STEPS];
  logic signed [ANG_W-1:0] ang [0:CORDIC_STEPS];
  item_t                   itm [0:CORDIC_STEPS];
  logic                    vld [0:CORDIC_STEPS];

  logic signed [XY_W-1:0]  x_scaled;
  logic signed [XY_W-1:0]  y_scaled;

  logic                    mul_vld;
  item_t                   mul_item;
  logic signed [NUM_W-1:0] mul_num;

  logic                    sum_vld;
  item_t                   sum_item;
  logic signed [HD_W-1:0]  sum_hd;
  logic signed [Q_W-1:0]   q_raw;
  logic signed [Q_W-1:0]   q_clamped;
  logic signed [AXIS_W-1:0] decl_clamped;

  logic signed [HD_W-1:0]  hd_wrapped;

  assign advance = !m_axis_tvalid || m_axis_tready;
  assign q_pop   = advance && !q_empty;

  assign x_scaled = {{(XY_W-AXIS_W-8){q_item.x[AXIS_W-1]}}, q_item.x, 8'b0};
  assign y_scaled = {{(XY_W-AXIS_W-8){q_item.y[AXIS_W-1]}}, q_item.y, 8'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (advance) begin
      vld[0] <= !q_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      itm[0] <= q_item;
      if (q_item.x[AXIS_W-1]) begin
        cx[0]  <= -x_scaled;
        cy[0]  <= -y_scaled;
        ang[0] <= q_item.y[AXIS_W-1] ? -HALF_TURN_ANG : HALF_TURN_ANG;
      end else begin
        cx[0]  <= x_scaled;
        cy[0]  <= y_scaled;
        ang[0] <= '0;
      end
    end
  end

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
    logic signed [XY_W-1:0] sx;
    logic signed [XY_W-1:0] sy;

    assign sx = cx[k] >>> k;
    assign sy = cy[k] >>> k;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (advance) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        itm[k+1] <= itm[k];
        if (!cy[k][XY_W-1]) begin
          cx[k+1]  <= cx[k] + sy;
          cy[k+1]  <= cy[k] - sx;
          ang[k+1] <= ang[k] + atan_entry(k);
        end else begin
          cx[k+1]  <= cx[k] - sy;
          cy[k+1]  <= cy[k] + sx;
          ang[k+1] <= ang[k] - atan_entry(k);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_vld       <= 1'b0;
      sum_vld       <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      mul_vld       <= vld[CORDIC_STEPS];
      sum_vld       <= mul_vld;
      m_axis_tvalid <= sum_vld;
    end
  end

  always_comb begin
    q_raw = mul_num[NUM_W-1:16];
    if (mul_item.zero) begin
      q_clamped = '0;
    end else if (q_raw > HALF_TURN_Q) begin
      q_clamped = HALF_TURN_Q;
    end else if (q_raw < -HALF_TURN_Q) begin
      q_clamped = -HALF_TURN_Q;
    end else begin
      q_clamped = q_raw;
    end
    if (decl > HALF_TURN_DECL) begin
      decl_clamped = HALF_TURN_DECL;
    end else if (decl < -HALF_TURN_DECL) begin
      decl_clamped = -HALF_TURN_DECL;
    end else begin
      decl_clamped = decl;
    end
  end

  always_comb begin
    if (sum_hd < 0) begin
      hd_wrapped = sum_hd + FULL_TURN_HD;
    end else if (sum_hd >= FULL_TURN_HD) begin
      hd_wrapped = sum_hd - FULL_TURN_HD;
    end else begin
      hd_wrapped = sum_hd;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      mul_item <= itm[CORDIC_STEPS];
      mul_num  <= NUM_W'(ang[CORDIC_STEPS]) * CD_PER_DEG + ROUND_HALF;
      sum_item <= mul_item;
      sum_hd   <= HD_W'(q_clamped) + HD_W'(decl_clamped);
      m_axis_tuser        <= sum_item.ok;
      m_axis_tdata[15:0]  <= sum_item.ok ? hd_wrapped[15:0] : 16'd0;
      m_axis_tdata[31:16] <= sum_item.x;
      m_axis_tdata[47:32] <= sum_item.y;
      m_axis_tdata[63:48] <= sum_item.z;
    end
  end

endmodule

// ===== rtl/magnetometer_heading.sv =====
// ---------------------------------------------------------------------------
// magnetometer_heading: compass heading from one six-byte magnetometer read
// Each input word carries the six raw bytes of one read and a transfer flag.
// The output word carries the heading in hundredths of a degree, the three
// unpacked axes and a flag that is set when a sensor is configured and the
// transfer succeeded; otherwise every output field is zero.
// The configuration port sets the chip variant and the declination; the user
// must write it only while no word is in flight; the block does not enforce this.
// One output word follows each input word, in order. An input stage, a
// four-entry queue and a pipeline of pre-rotation, CORDIC, centidegree and
// declination stages and the output register give a rate of one word per
// cycle while the receiver does not stall, set by the one-step-per-stage CORDIC.
// When the receiver stalls, the output register holds its word and the
// pipeline halts; the queue then fills and s_axis_tready falls.
// Reset empties the queue and the pipeline and sets the variant to no
// sensor and the declination to zero.
// ---------------------------------------------------------------------------
module magnetometer_heading
  import mhdg_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [47:0]            s_axis_tdata,  // byte0 .. byte5
  input  logic                   s_axis_tuser,  // transfer_ok
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [63:0]            m_axis_tdata,  // heading_centideg, raw_x, raw_y, raw_z
  output logic                   m_axis_tuser   // heading_ok
);

  logic [1:0]               variant;
  logic signed [AXIS_W-1:0] decl;
  logic                     q_push;
  logic                     q_full;
  logic                     q_pop;
  logic                     q_empty;
  item_t                    push_item;
  item_t                    pop_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      variant <= VARIANT_NONE;
      decl    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_VARIANT: variant <= cfg_data[1:0];
        REG_DECL:    decl    <= cfg_data;
        default:     ;
      endcase
    end
  end

  mhdg_front u_front (
    .clk           (clk),
    .rst           (rst),
    .variant       (variant),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_item        (push_item)
  );

  mhdg_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (pop_item),
    .empty     (q_empty)
  );

  mhdg_back #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .decl          (decl),
    .q_empty       (q_empty),
    .q_item        (pop_item),
    .q_pop         (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  a_heading_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[15:0] < 16'd36000))
    else $error("heading outside one turn");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == 64'd0))
    else $error("invalid word carries non-zero fields");

  a_queue_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !q_push)
    else $error("push into a full queue");

  a_queue_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_empty |-> !q_pop)
    else $error("pop from an empty queue");

endmodule

// ===== test/tb.sv =====
// ---------------------------------------------------------------------------
// tb: self-checking bench for magnetometer_heading
// Six-byte reads are fed in across a range of chip variant and declination
// settings. Every heading word that comes out is compared against a CORDIC
// predictor in the scoreboard. Both stream sides idle at random. One phase
// holds the receiver off for a long stretch so that the block has to stall
// its input.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

import mhdg_pkg::*;

typedef struct packed {
  logic                     ok;
  logic [15:0]              heading;
  logic signed [AXIS_W-1:0] x;
  logic signed [AXIS_W-1:0] y;
  logic signed [AXIS_W-1:0] z;
} heading_word_t;

class heading_scoreboard;
  heading_word_t            expected_words[$];
  logic [1:0]               variant;
  logic signed [15:0]       declination;
  longint                   angle_step[24];
  int                       reads_seen;
  int                       words_checked;
  int                       valid_headings;
  int                       mismatches;

  function new();
    angle_step = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
                   14668, 7334, 3667, 1833, 917, 458, 229, 115,
                   57, 29, 14, 7, 4, 2, 1, 0};
    variant = VARIANT_NONE;
    declination = '0;
    reads_seen = 0;
    words_checked = 0;
    valid_headings = 0;
    mismatches = 0;
  endfunction

  function automatic heading_word_t heading_of(logic ok_in, logic [47:0] bytes);
    heading_word_t      w;
    logic [7:0]         b[6];
    logic signed [15:0] ax, ay, az;
    longint             cx, cy, ang, sx, sy, q, decl, h;
    int                 i;
    int                 steps;
    w = '0;
    if (!ok_in || (variant != VARIANT_LE && variant != VARIANT_BE))
      return w;
    for (i = 0; i < 6; i++)
      b[i] = bytes[8*i +: 8];
    if (variant == VARIANT_LE) begin
      ax = {b[1], b[0]};
      ay = {b[3], b[2]};
      az = {b[5], b[4]};
    end else begin
      ax = {b[0], b[1]};
      az = {b[2], b[3]};
      ay = {b[4], b[5]};
    end
    q = 0;
    if (ax != 0 || ay != 0) begin
      cx = longint'(ax) * 256;
      cy = longint'(ay) * 256;
      ang = 0;
      // Vectors in the left half-plane are turned through half a turn first.
      if (ax < 0) begin
        ang = (ay >= 0) ? 180 * 65536 : -180 * 65536;
        cx = -cx;
        cy = -cy;
      end
      steps = (CORDIC_STEPS_DEF < 24) ? CORDIC_STEPS_DEF : 24;
      for (i = 0; i < steps; i++) begin
        sx = cx >>> i;
        sy = cy >>> i;
        if (cy >= 0) begin
          cx = cx + sy;
          cy = cy - sx;
          ang = ang + angle_step[i];
        end else begin
          cx = cx - sy;
          cy = cy + sx;
          ang = ang - angle_step[i];
        end
      end
      q = (ang * 100 + 32768) >>> 16;
      if (q > 18000) q = 18000;
      if (q < -18000) q = -18000;
    end
    decl = longint'(declination);
    if (decl > 18000) decl = 18000;
    if (decl < -18000) decl = -18000;
    h = q + decl;
    if (h < 0) h = h + 36000;
    if (h >= 36000) h = h - 36000;
    w.ok = 1'b1;
    w.heading = h[15:0];
    w.x = ax;
    w.y = ay;
    w.z = az;
    return w;
  endfunction

  function void note_read(logic ok_in, logic [47:0] bytes);
    heading_word_t w;
    w = heading_of(ok_in, bytes);
    expected_words.push_back(w);
    reads_seen++;
    if (w.ok) valid_headings++;
  endfunction

  function void check_word(logic [63:0] data, logic user);
    heading_word_t exp_w, got;
    got.ok = user;
    got.heading = data[15:0];
    got.x = data[31:16];
    got.y = data[47:32];
    got.z = data[63:48];
    if (expected_words.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: output word with none expected: ok=%0d heading=%0d", $realtime,
                 got.ok, got.heading);
      return;
    end
    exp_w = expected_words.pop_front();
    words_checked++;
    if (got !== exp_w) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: mismatch: expected ok=%0d hdg=%0d x=%0d y=%0d z=%0d, got ok=%0d hdg=%0d x=%0d y=%0d z=%0d",
                 $realtime, exp_w.ok, exp_w.heading, exp_w.x, exp_w.y, exp_w.z,
                 got.ok, got.heading, got.x, got.y, got.z);
    end
  endfunction

  function int pending();
    return expected_words.size();
  endfunction
endclass

module tb;
  localparam int LONG_HOLD = 300;
  localparam int DIR_X[11] = '{0, 1, 0, -1, -1, 0, 32767, -32768, -32768, -32768, 32767};
  localparam int DIR_Y[11] = '{0, 0, 1, 0, -1, -1, 32767, -32768, 0, -1, -32768};
  localparam int EDGE_VAL[5] = '{-32768, -1, 0, 1, 32767};

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [47:0]            s_axis_tdata;  // byte0 .. byte5
  logic                   s_axis_tuser;  // transfer_ok
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [63:0]            m_axis_tdata;  // heading_centideg, raw_x, raw_y, raw_z
  logic                   m_axis_tuser;  // heading_ok

  heading_scoreboard sb;
  bit                idle_on;
  bit                long_hold_req;
  logic [1:0]        cur_variant;
  int                settings_used;

  magnetometer_heading dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb NOT OK");
    $finish;
  end

  // Receiver: random stall bursts, plus one long hold when asked for.
  initial begin
    int stall_left;
    stall_left = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left = LONG_HOLD - 1;
        m_axis_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 9);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready)
      sb.note_read(s_axis_tuser, s_axis_tdata);
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_word(m_axis_tdata, m_axis_tuser);
  end

  function automatic logic [47:0] pack_axes(logic [1:0] v, logic [15:0] ax, logic [15:0] ay,
                                            logic [15:0] az);
    if (v == VARIANT_BE)
      return {ay[7:0], ay[15:8], az[7:0], az[15:8], ax[7:0], ax[15:8]};
    return {az[15:8], az[7:0], ay[15:8], ay[7:0], ax[15:8], ax[7:0]};
  endfunction

  function automatic logic [15:0] edge_axis();
    return 16'(EDGE_VAL[$urandom_range(0, 4)]);
  endfunction

  task automatic send_word(input logic ok, input logic [47:0] bytes);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= bytes;
    s_axis_tuser <= ok;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic send_random();
    logic [15:0] ax, ay, az;
    logic [47:0] bytes;
    logic        ok;
    int          kind;
    kind = $urandom_range(0, 9);
    ok = ($urandom_range(0, 9) != 0);
    if (kind <= 5) begin
      bytes = {16'($urandom), 32'($urandom)};
    end else begin
      if (kind <= 7) begin
        ax = 16'($urandom_range(0, 8) - 4);
        ay = 16'($urandom_range(0, 8) - 4);
        az = 16'($urandom);
      end else begin
        ax = edge_axis();
        ay = edge_axis();
        az = edge_axis();
      end
      bytes = pack_axes(cur_variant, ax, ay, az);
    end
    send_word(ok, bytes);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    if (idx == REG_VARIANT)
      sb.variant = data[1:0];
    else
      sb.declination = data;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    do begin
      @(posedge clk);
      guard++;
    end while (sb.pending() != 0 && guard < 20000);
  endtask

  task automatic configure(input logic [1:0] v, input int decl);
    s_axis_tvalid <= 1'b0;
    wait_drained();
    write_reg(REG_VARIANT, {{(CFG_DATA_W-2){1'b0}}, v});
    write_reg(REG_DECL, 16'(decl));
    cur_variant = v;
    settings_used++;
  endtask

  task automatic send_directed();
    int i;
    for (i = 0; i < 11; i++)
      send_word(1'b1, pack_axes(cur_variant, 16'(DIR_X[i]), 16'(DIR_Y[i]),
                                (i % 2 == 0) ? 16'h8000 : 16'h7FFF));
    send_word(1'b0, {48{1'b1}});
  endtask

  task automatic random_phase(input logic [1:0] v, input int decl, input int n,
                              input bit with_idle, input bit with_hold);
    configure(v, decl);
    idle_on = with_idle;
    if (with_hold) long_hold_req = 1'b1;
    repeat (n) send_random();
  endtask

  initial begin
    sb = new();
    idle_on = 1'b1;
    long_hold_req = 1'b0;
    cur_variant = VARIANT_NONE;
    settings_used = 0;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= REG_VARIANT;
    cfg_data <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    configure(VARIANT_LE, 0);
    send_directed();
    configure(VARIANT_BE, 18000);
    send_directed();

    random_phase(VARIANT_NONE, $urandom_range(0, 36000) - 18000, 150, 1'b1, 1'b0);
    random_phase(VARIANT_LE, -18000, 190, 1'b1, 1'b0);
    random_phase(VARIANT_BE, 32767, 190, 1'b1, 1'b0);
    random_phase(VARIANT_LE, -32768, 190, 1'b1, 1'b0);
    random_phase(2'd3, 5000, 120, 1'b1, 1'b0);
    random_phase(VARIANT_BE, $urandom_range(0, 36000) - 18000, 200, 1'b1, 1'b0);
    random_phase(VARIANT_LE, $urandom_range(0, 36000) - 18000, 200, 1'b0, 1'b1);
    random_phase(VARIANT_BE, $urandom_range(0, 65535), 200, 1'b1, 1'b0);
    random_phase(VARIANT_LE, 18000, 150, 1'b0, 1'b0);

    s_axis_tvalid <= 1'b0;
    wait_drained();
    repeat (CORDIC_STEPS_DEF + 10) @(posedge clk);

    $display("Fed %0d reads over %0d register settings, %0d with a valid heading.",
             sb.reads_seen, settings_used, sb.valid_headings);
    $display("Checked %0d output words, %0d mismatches, %0d still outstanding.",
             sb.words_checked, sb.mismatches, sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end
endmodule

// ===== magnetometer_heading.f =====
rtl/mhdg_pkg.sv
rtl/mhdg_front.sv
rtl/mhdg_queue.sv
rtl/mhdg_back.sv
rtl/magnetometer_heading.sv
test/tb.sv
